// ===== hdl/uci_packet_deframer_core_macros.svh =====
// Assertion helpers shared by the deframer checker.
`ifndef UCI_PACKET_DEFRAMER_CORE_MACROS_SVH
`define UCI_PACKET_DEFRAMER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define UPD_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define UPD_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/upd_pkg.sv =====
`default_nettype none

package upd_pkg;

    // Header field layout of header byte zero
    localparam int TYPE_MSB     = 7;
    localparam int TYPE_LSB     = 5;
    localparam int BOUNDARY_BIT = 4;
    localparam int GROUP_MSB    = 3;

    // Message type codes (3-bit field on the wire)
    localparam logic [2:0] MT_DATA         = 3'd0;
    localparam logic [2:0] MT_NOTIFICATION = 3'd3;

    // Result queue between parser and output stage
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Output word widths
    localparam int TDATA_W = 40;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_H0      = 5'b00001,
        PH_H1      = 5'b00010,
        PH_H2      = 5'b00100,
        PH_H3      = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    // One result as handed from the parser to the output stage
    typedef struct packed {
        logic [7:0]  hdr0;
        logic [7:0]  opcode;
        logic [15:0] length;
        logic [7:0]  data;
        logic        byte_valid;
        logic        last;
    } entry_t;

endpackage

`default_nettype wire

// ===== hdl/upd_front.sv =====
`default_nettype none

module upd_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,
    input  wire logic            q_ready,
    output logic                 q_push,
    output upd_pkg::entry_t      q_entry
);

    upd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  hdr0_reg, hdr0_next;
    logic [7:0]  hdr1_reg, hdr1_next;
    logic [7:0]  hdr2_reg, hdr2_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] hdr_length;
    logic        accept;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;

    // Length from header: 16-bit little endian for data, byte three otherwise
    always_comb begin
        if (hdr0_reg[upd_pkg::TYPE_MSB:upd_pkg::TYPE_LSB] == upd_pkg::MT_DATA) begin
            hdr_length = {s_tdata, hdr2_reg};
        end else begin
            hdr_length = {8'd0, s_tdata};
        end
    end

    // Classify the incoming word by phase
    always_comb begin
        phase_next  = phase_reg;
        hdr0_next   = hdr0_reg;
        hdr1_next   = hdr1_reg;
        hdr2_next   = hdr2_reg;
        length_next = length_reg;
        left_next   = left_reg;
        q_push      = 1'b0;
        q_entry     = '0;
        q_entry.hdr0   = hdr0_reg;
        q_entry.opcode = hdr1_reg;
        q_entry.length = length_reg;
        if (accept) begin
            unique case (phase_reg)
                upd_pkg::PH_H1: begin
                    hdr1_next  = s_tdata;
                    phase_next = upd_pkg::PH_H2;
                end
                upd_pkg::PH_H2: begin
                    hdr2_next  = s_tdata;
                    phase_next = upd_pkg::PH_H3;
                end
                upd_pkg::PH_H3: begin
                    length_next = hdr_length;
                    left_next   = hdr_length;
                    if (hdr_length == 16'd0) begin
                        // empty packet: one result with no byte
                        phase_next       = upd_pkg::PH_H0;
                        q_push           = 1'b1;
                        q_entry.length   = hdr_length;
                        q_entry.last     = 1'b1;
                    end else begin
                        phase_next = upd_pkg::PH_PAYLOAD;
                    end
                end
                upd_pkg::PH_PAYLOAD: begin
                    left_next          = left_reg - 16'd1;
                    q_push             = 1'b1;
                    q_entry.data       = s_tdata;
                    q_entry.byte_valid = 1'b1;
                    q_entry.last       = (left_reg == 16'd1);
                    if (left_reg == 16'd1) begin
                        phase_next = upd_pkg::PH_H0;
                    end
                end
                default: begin
                    // drop bytes with an unknown type to resync
                    if (s_tdata[upd_pkg::TYPE_MSB:upd_pkg::TYPE_LSB]
                            <= upd_pkg::MT_NOTIFICATION) begin
                        hdr0_next  = s_tdata;
                        phase_next = upd_pkg::PH_H1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= upd_pkg::PH_H0;
        end else begin
            phase_reg <= phase_next;
        end
        hdr0_reg   <= hdr0_next;
        hdr1_reg   <= hdr1_next;
        hdr2_reg   <= hdr2_next;
        length_reg <= length_next;
        left_reg   <= left_next;
    end

endmodule

`default_nettype wire

// ===== hdl/upd_queue.sv =====
`default_nettype none

module upd_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire upd_pkg::entry_t push_entry,
    output logic                 push_ready,
    input  wire logic            pop,
    output logic                 pop_valid,
    output upd_pkg::entry_t      pop_entry
);

    upd_pkg::entry_t mem_reg [upd_pkg::QUEUE_DEPTH];
    logic [upd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [upd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [upd_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push_ready = (count_reg != upd_pkg::QUEUE_CNT_W'(upd_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == upd_pkg::QUEUE_PTR_W'(upd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == upd_pkg::QUEUE_PTR_W'(upd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/upd_back.sv =====
`default_nettype none

module upd_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    input  wire upd_pkg::entry_t              q_entry,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [upd_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    logic                         valid_reg, valid_next;
    logic [upd_pkg::TDATA_W-1:0]  data_reg, data_next;
    logic                         user_reg, user_next;
    logic                         last_reg, last_next;
    logic                         load;

    // Refill the output register when empty or being drained
    assign load  = q_valid && (!valid_reg || m_tready);
    assign q_pop = load;

    // Unpack header byte zero and pack the output word
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = {1'b0,
                          q_entry.data,
                          q_entry.length,
                          q_entry.hdr0[upd_pkg::BOUNDARY_BIT],
                          q_entry.opcode,
                          q_entry.hdr0[upd_pkg::GROUP_MSB:0],
                          q_entry.hdr0[upd_pkg::TYPE_LSB+1:upd_pkg::TYPE_LSB]};
            user_next  = q_entry.byte_valid;
            last_next  = q_entry.last;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== hdl/uci_packet_deframer_core.sv =====
// Path: a result word goes through the result queue, then the output register, to m_.
// Throughput: one input word per cycle while the two-entry result queue has room;
// the queue absorbs a stall on the m_ side until it is full, then s_tready drops.
// Reset: synchronous, active low; clears parser phase, queue occupancy and output valid.
`default_nettype none

module uci_packet_deframer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] msg_type, [5:2] group_id, [13:6] opcode_id, [14] boundary_flag,
    // [30:15] payload_length, [38:31] payload_byte, [39] zero
    output logic [39:0]      m_tdata,
    output logic             m_tuser,   // [0] byte_valid
    output logic             m_tlast
);

    logic            q_ready;
    logic            q_push;
    upd_pkg::entry_t push_entry;
    logic            q_pop;
    logic            q_valid;
    upd_pkg::entry_t pop_entry;

    upd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    upd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry)
    );

    upd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hdl/upd_checker.sv =====
`default_nettype none

`include "uci_packet_deframer_core_macros.svh"

module upd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // Output stays offered until taken
    `UPD_ASSERT_RUN(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")
    // A stalled word keeps its data
    `UPD_ASSERT_RUN(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata moved")
    // An empty packet result closes its packet with zero length
    `UPD_ASSERT_RUN(a_empty_last, m_tvalid && !m_tuser |-> m_tlast && m_tdata[30:15] == 16'd0, "bad empty packet word")
    // Nothing is offered right after reset
    `UPD_ASSERT_ALL(a_reset_idle, !aresetn |=> !m_tvalid, "m_tvalid after reset")

endmodule

bind uci_packet_deframer_core upd_checker u_upd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== dv/uci_packet_deframer_core_tb.sv =====
`default_nettype none

module uci_packet_deframer_core_tb;

    // Message types as they appear in the two-bit result field
    localparam logic [1:0] MSG_DATA     = 2'd0;
    localparam logic [1:0] MSG_COMMAND  = 2'd1;
    localparam logic [1:0] MSG_RESPONSE = 2'd2;
    localparam logic [1:0] MSG_NOTIFY   = 2'd3;

    localparam int ITEM_TARGET  = 1250;
    localparam int DIRECTED_LEN = 26;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 2000000;

    // One result word, fields in port order
    typedef struct packed {
        logic [1:0]  msg_type;
        logic [3:0]  group_id;
        logic [7:0]  opcode_id;
        logic        boundary;
        logic [15:0] length;
        logic [7:0]  data;
        logic        byte_valid;
        logic        last;
    } packet_word_t;

    // One directed row: the byte, and a hand-written result where it is obvious
    typedef struct packed {
        logic [7:0]   rx;
        logic         typed;
        packet_word_t word;
    } stim_row_t;

    localparam packet_word_t NO_WORD = '0;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Deframer state as predicted
    upd_pkg::phase_t parse_phase = upd_pkg::PH_H0;
    logic [7:0]  hdr_type    = 8'h00;
    logic [7:0]  hdr_opcode  = 8'h00;
    logic [7:0]  hdr_len_lo  = 8'h00;
    logic [15:0] pkt_length  = 16'h0000;
    logic [15:0] pkt_left    = 16'h0000;

    packet_word_t pending_words[$];

    bit no_idle     = 1'b0;
    int errors      = 0;
    int items_sent  = 0;
    int noise_sent  = 0;
    int words_seen  = 0;
    int packets_end = 0;
    int empty_seen  = 0;
    int stall_left  = 0;
    int longest_len = 0;

    stim_row_t directed_rows [DIRECTED_LEN] = '{
        // bytes with an illegal type are dropped while hunting for a header
        '{8'hE0, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'h80, 1'b0, NO_WORD},
        // empty command, all header bits set, byte two ignored
        '{8'h3F, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'hAA, 1'b0, NO_WORD},
        '{8'h00, 1'b1, '{MSG_COMMAND, 4'hF, 8'hFF, 1'b1, 16'd0, 8'h00, 1'b0, 1'b1}},
        // empty data packet, all header bits clear
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b1, '{MSG_DATA, 4'h0, 8'h00, 1'b0, 16'd0, 8'h00, 1'b0, 1'b1}},
        // one-byte notification, byte two all ones and ignored
        '{8'h6A, 1'b0, NO_WORD},
        '{8'h81, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'h01, 1'b0, NO_WORD},
        '{8'hFF, 1'b1, '{MSG_NOTIFY, 4'hA, 8'h81, 1'b0, 16'd1, 8'hFF, 1'b1, 1'b1}},
        // two-byte data packet, little-endian length
        '{8'h1C, 1'b0, NO_WORD},
        '{8'h5C, 1'b0, NO_WORD},
        '{8'h02, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b1, '{MSG_DATA, 4'hC, 8'h5C, 1'b1, 16'd2, 8'h00, 1'b1, 1'b0}},
        '{8'hFF, 1'b1, '{MSG_DATA, 4'hC, 8'h5C, 1'b1, 16'd2, 8'hFF, 1'b1, 1'b1}},
        // empty response
        '{8'h45, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b1, '{MSG_RESPONSE, 4'h5, 8'h00, 1'b0, 16'd0, 8'h00, 1'b0, 1'b1}}
    };

    uci_packet_deframer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_CYCLES * 12);
        $display("%0t: timeout, %0d words still expected", $time, pending_words.size());
        $display("simulation failed");
        $finish;
    end

    // Mostly short gaps, a few long ones; none in a quiet stretch
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic packet_word_t make_word(input logic [7:0] data, input logic valid,
                                               input logic last);
        packet_word_t w;
        w.msg_type   = hdr_type[6:5];
        w.group_id   = hdr_type[3:0];
        w.opcode_id  = hdr_opcode;
        w.boundary   = hdr_type[4];
        w.length     = pkt_length;
        w.data       = valid ? data : 8'h00;
        w.byte_valid = valid;
        w.last       = last;
        return w;
    endfunction

    // Advance the parser by one byte; return 1 when a word comes out
    function automatic bit deframe_byte(input logic [7:0] b, output packet_word_t w);
        w = NO_WORD;
        case (parse_phase)
            upd_pkg::PH_H1: begin
                hdr_opcode  = b;
                parse_phase = upd_pkg::PH_H2;
                return 1'b0;
            end
            upd_pkg::PH_H2: begin
                hdr_len_lo  = b;
                parse_phase = upd_pkg::PH_H3;
                return 1'b0;
            end
            upd_pkg::PH_H3: begin
                // only data packets carry a 16-bit length
                if (hdr_type[7:5] == upd_pkg::MT_DATA) pkt_length = {b, hdr_len_lo};
                else pkt_length = {8'h00, b};
                if (pkt_length == 16'h0000) begin
                    pkt_left    = 16'h0000;
                    parse_phase = upd_pkg::PH_H0;
                    w = make_word(8'h00, 1'b0, 1'b1);
                    return 1'b1;
                end
                pkt_left    = pkt_length;
                parse_phase = upd_pkg::PH_PAYLOAD;
                return 1'b0;
            end
            upd_pkg::PH_PAYLOAD: begin
                pkt_left = pkt_left - 16'd1;
                if (pkt_left == 16'h0000) parse_phase = upd_pkg::PH_H0;
                w = make_word(b, 1'b1, pkt_left == 16'h0000);
                return 1'b1;
            end
            default: begin
                // drop bytes with an illegal type to resync
                if (b[7:5] > upd_pkg::MT_NOTIFICATION) begin
                    parse_phase = upd_pkg::PH_H0;
                end else begin
                    hdr_type    = b;
                    parse_phase = upd_pkg::PH_H1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Offer one word, hold it until taken, then predict
    task automatic send_byte(input logic [7:0] b, input logic typed, input packet_word_t tw);
        int gap;
        packet_word_t w;
        bit got;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        got = deframe_byte(b, w);
        if (typed) pending_words.insert(pending_words.size(), tw);
        else if (got) pending_words.insert(pending_words.size(), w);
    endtask

    // One packet with random content, sometimes behind line noise
    task automatic send_packet();
        logic [7:0]  h0;
        logic [7:0]  opc;
        logic [15:0] len;
        int r;
        int n;
        if ($urandom_range(0, 99) < 12) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                send_byte({3'($urandom_range(4, 7)), 5'($urandom)}, 1'b0, NO_WORD);
                noise_sent++;
            end
        end
        h0  = {1'b0, 2'($urandom), 5'($urandom)};
        opc = 8'($urandom);
        r   = $urandom_range(0, 99);
        if (r < 10) len = 16'd0;
        else if (r < 80) len = 16'($urandom_range(1, 8));
        else if (r < 95) len = 16'($urandom_range(9, 64));
        else if (h0[6:5] == MSG_DATA) len = 16'($urandom_range(65, 300));
        else len = 16'($urandom_range(65, 255));
        if (int'(len) > longest_len) longest_len = int'(len);
        send_byte(h0, 1'b0, NO_WORD);
        send_byte(opc, 1'b0, NO_WORD);
        if (h0[6:5] == MSG_DATA) begin
            send_byte(len[7:0], 1'b0, NO_WORD);
            send_byte(len[15:8], 1'b0, NO_WORD);
        end else begin
            send_byte(8'($urandom), 1'b0, NO_WORD);
            send_byte(len[7:0], 1'b0, NO_WORD);
        end
        items_sent += 4;
        for (int i = 0; i < int'(len); i++) send_byte(8'($urandom), 1'b0, NO_WORD);
        items_sent += int'(len);
    endtask

    task automatic field_cmp(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Check result words and randomize the result-side stall
    always @(posedge aclk) begin
        packet_word_t got_w;
        packet_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            got_w.msg_type   = m_tdata[1:0];
            got_w.group_id   = m_tdata[5:2];
            got_w.opcode_id  = m_tdata[13:6];
            got_w.boundary   = m_tdata[14];
            got_w.length     = m_tdata[30:15];
            got_w.data       = m_tdata[38:31];
            got_w.byte_valid = m_tuser;
            got_w.last       = m_tlast;
            words_seen++;
            if (got_w.last) packets_end++;
            if (got_w.last && !got_w.byte_valid) empty_seen++;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, got_w);
                errors++;
            end else begin
                exp_w = pending_words.pop_front();
                field_cmp("msg_type", exp_w.msg_type, got_w.msg_type);
                field_cmp("group_id", exp_w.group_id, got_w.group_id);
                field_cmp("opcode_id", exp_w.opcode_id, got_w.opcode_id);
                field_cmp("boundary_flag", exp_w.boundary, got_w.boundary);
                field_cmp("payload_length", exp_w.length, got_w.length);
                field_cmp("payload_byte", exp_w.data, got_w.data);
                field_cmp("byte_valid", exp_w.byte_valid, got_w.byte_valid);
                field_cmp("last", exp_w.last, got_w.last);
            end
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_LEN; i++)
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].word);

        // random packets, some stretches without idling
        while (items_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 99) < 15);
            send_packet();
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d packet bytes and %0d noise bytes; checked %0d result words.",
                 items_sent, noise_sent, words_seen);
        $display("Closed %0d packets, %0d of them empty, the longest %0d bytes.",
                 packets_end, empty_seen, longest_len);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
